/* rtl/dq_pkg.sv */
// Shared types and codes for the double-ended queue.
package dq_pkg;

    localparam logic [2:0] CMD_PUSH_REAR  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_REAR   = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_LIST       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Entries in the request queue between front and back.
    localparam int OPQ_DEPTH = 2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_res;
        logic               last;
    } out_t;

    // Decoded request as the back end sees it.
    typedef struct packed {
        logic               is_push;
        logic               is_pop;
        logic               is_list;
        logic               at_front;
        logic signed [31:0] value;
    } op_t;

endpackage

/* rtl/dq_front.sv */
// Front end: accepts requests, decodes them and drops unused command codes.
module dq_front
(
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  dq_pkg::in_t   cmd,
    output logic          op_valid,
    input  logic          op_ready,
    output dq_pkg::op_t   op
);

    logic known;

    always_comb
    begin
        op.is_push  = 1'b0;
        op.is_pop   = 1'b0;
        op.is_list  = 1'b0;
        op.at_front = 1'b0;
        op.value    = cmd.value;
        known       = 1'b1;
        case (cmd.command)
            dq_pkg::CMD_PUSH_REAR:
            begin
                op.is_push = 1'b1;
            end
            dq_pkg::CMD_PUSH_FRONT:
            begin
                op.is_push  = 1'b1;
                op.at_front = 1'b1;
            end
            dq_pkg::CMD_POP_REAR:
            begin
                op.is_pop = 1'b1;
            end
            dq_pkg::CMD_POP_FRONT:
            begin
                op.is_pop   = 1'b1;
                op.at_front = 1'b1;
            end
            dq_pkg::CMD_LIST:
            begin
                op.is_list = 1'b1;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Unused codes are taken at once and produce nothing.
    assign op_valid  = cmd_valid && known;
    assign cmd_ready = known ? op_ready : 1'b1;

endmodule

/* rtl/dq_opq.sv */
// Small request queue between the front end and the back end.
module dq_opq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  dq_pkg::op_t   wr_op,
    output logic          rd_valid,
    input  logic          rd_ready,
    output dq_pkg::op_t   rd_op
);

    localparam int PW = (dq_pkg::OPQ_DEPTH > 1) ? $clog2(dq_pkg::OPQ_DEPTH) : 1;
    localparam int NW = $clog2(dq_pkg::OPQ_DEPTH + 1);

    dq_pkg::op_t slot_reg [dq_pkg::OPQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_wr, do_rd;

    assign wr_ready = fill_reg != NW'(dq_pkg::OPQ_DEPTH);
    assign rd_valid = fill_reg != '0;
    assign rd_op    = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(dq_pkg::OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(dq_pkg::OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

/* rtl/dq_back.sv */
// Back end: circular entry store, front pointer, count and result register.
module dq_back
#(
    parameter int DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  dq_pkg::op_t   op,
    output logic          res_valid,
    input  logic          res_ready,
    output dq_pkg::out_t  res
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LIST = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          last_pend_reg, last_pend_next;
    logic          res_valid_reg, res_valid_next;
    dq_pkg::out_t  res_reg, res_next;

    logic               we, re;
    logic [IW-1:0]      waddr, raddr;
    logic signed [31:0] wdata;

    logic          out_free, full, empty;
    logic [IW:0]   rear_sum, back_sum, list_sum;
    logic [IW-1:0] rear_slot, back_slot, list_slot, front_dec, front_inc;

    assign out_free = !res_valid_reg || res_ready;
    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;

    // Slot addresses: front plus an offset, wrapped once at DEPTH.
    assign rear_sum  = {1'b0, front_reg} + (IW+1)'(count_reg);
    assign back_sum  = {1'b0, front_reg} + (IW+1)'(count_reg) - 1'b1;
    assign list_sum  = {1'b0, front_reg} + {1'b0, idx_reg};
    assign rear_slot = (rear_sum >= (IW+1)'(DEPTH)) ? IW'(rear_sum - (IW+1)'(DEPTH))
                                                   : IW'(rear_sum);
    assign back_slot = (back_sum >= (IW+1)'(DEPTH)) ? IW'(back_sum - (IW+1)'(DEPTH))
                                                   : IW'(back_sum);
    assign list_slot = (list_sum >= (IW+1)'(DEPTH)) ? IW'(list_sum - (IW+1)'(DEPTH))
                                                   : IW'(list_sum);
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        last_pend_next = last_pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        op_ready       = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = rear_slot;
        raddr          = back_slot;
        wdata          = op.value;

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_ready = 1'b1;
                    if (op.is_push)
                    begin
                        res_valid_next = 1'b1;
                        res_next.last  = 1'b1;
                        if (full)
                        begin
                            res_next.status    = dq_pkg::ST_FULL;
                            res_next.value_res = '0;
                        end
                        else
                        begin
                            we = 1'b1;
                            if (op.at_front)
                            begin
                                waddr      = front_dec;
                                front_next = front_dec;
                            end
                            count_next         = count_reg + 1'b1;
                            res_next.status    = dq_pkg::ST_OK;
                            res_next.value_res = op.value;
                        end
                    end
                    else if (op.is_pop || op.is_list)
                    begin
                        if (empty)
                        begin
                            res_valid_next     = 1'b1;
                            res_next.status    = dq_pkg::ST_EMPTY;
                            res_next.value_res = '0;
                            res_next.last      = 1'b1;
                        end
                        else if (op.is_list)
                        begin
                            idx_next   = '0;
                            state_next = S_LIST;
                        end
                        else
                        begin
                            re = 1'b1;
                            if (op.at_front)
                            begin
                                raddr      = front_reg;
                                front_next = front_inc;
                            end
                            count_next     = count_reg - 1'b1;
                            last_pend_next = 1'b1;
                            state_next     = S_READ;
                        end
                    end
                end
            end
            S_LIST:
            begin
                // Issue one read per entry, waiting for the result register.
                if (out_free)
                begin
                    re             = 1'b1;
                    raddr          = list_slot;
                    last_pend_next = (CW'(idx_reg) + 1'b1) == count_reg;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                res_valid_next     = 1'b1;
                res_next.status    = dq_pkg::ST_OK;
                res_next.value_res = rd_data_reg;
                res_next.last      = last_pend_reg;
                state_next         = last_pend_reg ? S_IDLE : S_LIST;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            last_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            last_pend_reg <= last_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/double_ended_queue.sv */
// Top level of the double-ended queue: front end, request queue and back end.
//
//   channel   handshake             payload
//   cmd       cmd_valid/cmd_ready   dq_pkg::in_t  (command, value)
//   res       res_valid/res_ready   dq_pkg::out_t (status, value_res, last)
//
// A push is done in the back end's idle state and loads the result register;
// a pop reads the store, then loads the result register. A list reads each
// entry held in turn, each read waiting for the result register to free.
// Reset clears the pointers and count; store contents are undefined until pushed.
// A stalled result blocks the back end only; the front end keeps taking
// requests until its two-entry queue is full.
module double_ended_queue
#(
    parameter int DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  dq_pkg::in_t   cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output dq_pkg::out_t  res
);

    logic        fq_valid, fq_ready;
    dq_pkg::op_t fq_op;
    logic        bq_valid, bq_ready;
    dq_pkg::op_t bq_op;

    dq_front u_front
    (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .op_valid  (fq_valid),
        .op_ready  (fq_ready),
        .op        (fq_op)
    );

    dq_opq u_opq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_op    (fq_op),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_op    (bq_op)
    );

    dq_back #(.DEPTH(DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (bq_valid),
        .op_ready  (bq_ready),
        .op        (bq_op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
